// ===== rtl/core/matrix3x3_inverse_assert.svh =====
// ============================================================================
// matrix3x3_inverse_assert.svh
// Assertion macros for the 3x3 inverse RTL.
// ============================================================================
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MI3_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MI3_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mi3_pkg.sv =====
// ============================================================================
// mi3_pkg
// Widths, latencies and cofactor index tables for the 3x3 inverse.
// ============================================================================
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SH        = 2 * FRAC_BITS;     // numerator scale shift
    localparam int IN_W      = 32;
    localparam int PROD_W    = 2 * IN_W;
    localparam int ADJ_W     = PROD_W + 1;        // cofactor width
    localparam int LO_W      = 32;                // low slice of cofactor
    localparam int HI_W      = ADJ_W - LO_W;      // signed high slice
    localparam int PP_W      = IN_W + HI_W;       // partial product width
    localparam int DET_W     = ADJ_W + IN_W + 2;  // determinant width
    localparam int DV_W      = DET_W + 1 - SH;    // truncated determinant
    localparam int QBITS     = IN_W - 1;          // quotient magnitude bits
    localparam int NUM_W     = ADJ_W + SH;        // scaled numerator
    localparam int TOP_W     = NUM_W - QBITS;
    localparam int REM_W     = DET_W + 1;
    localparam int CMP_W     = (TOP_W > DET_W) ? TOP_W : DET_W;

    localparam int ADJ_LAT   = 2;
    localparam int DET_LAT   = 3;
    localparam int DIV_LAT   = QBITS + 2;
    localparam int LAT       = ADJ_LAT + DET_LAT + 1 + DIV_LAT;

    localparam logic signed [IN_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [IN_W-1:0] ELEM_MIN = 32'sh8000_0000;

    typedef logic signed [IN_W-1:0]  elem_t;
    typedef logic signed [ADJ_W-1:0] adj_t;
    typedef logic signed [DET_W-1:0] det_t;

    // cofactor k = m[A]*m[B] - m[C]*m[D], matrix index row*3+col
    localparam logic [3:0] CO_A [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam logic [3:0] CO_B [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam logic [3:0] CO_C [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam logic [3:0] CO_D [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

endpackage

// ===== rtl/core/mi3_adj.sv =====
// ============================================================================
// mi3_adj
// Two-stage adjugate: 18 products, then nine cofactor differences.
// ============================================================================
module mi3_adj (
    input  logic           clk,
    input  logic           adv,
    input  mi3_pkg::elem_t m     [9],
    output mi3_pkg::adj_t  adj   [9],
    output mi3_pkg::elem_t col   [3]
);

    logic signed [mi3_pkg::PROD_W-1:0] pa_reg [9];
    logic signed [mi3_pkg::PROD_W-1:0] pb_reg [9];
    mi3_pkg::adj_t  adj_reg  [9];
    mi3_pkg::elem_t col1_reg [3];
    mi3_pkg::elem_t col2_reg [3];

    // stage 1: products; stage 2: differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pa_reg[k]  <= m[mi3_pkg::CO_A[k]] * m[mi3_pkg::CO_B[k]];
                pb_reg[k]  <= m[mi3_pkg::CO_C[k]] * m[mi3_pkg::CO_D[k]];
                adj_reg[k] <= $signed({pa_reg[k][mi3_pkg::PROD_W-1], pa_reg[k]})
                            - $signed({pb_reg[k][mi3_pkg::PROD_W-1], pb_reg[k]});
            end
            for (int c = 0; c < 3; c++)
            begin
                col1_reg[c] <= m[3 * c];
                col2_reg[c] <= col1_reg[c];
            end
        end
    end

    assign adj = adj_reg;
    assign col = col2_reg;

endmodule

// ===== rtl/core/mi3_det.sv =====
// ============================================================================
// mi3_det
// Three-stage determinant: split products, shifted terms, final sum.
// Cofactors ride along to stay aligned with the determinant.
// ============================================================================
module mi3_det (
    input  logic           clk,
    input  logic           adv,
    input  mi3_pkg::elem_t col   [3],
    input  mi3_pkg::adj_t  adj   [9],
    output mi3_pkg::adj_t  adj_o [9],
    output mi3_pkg::det_t  det
);

    logic signed [mi3_pkg::PP_W-1:0] plo_reg [3];
    logic signed [mi3_pkg::PP_W-1:0] phi_reg [3];
    mi3_pkg::det_t term_reg [3];
    mi3_pkg::det_t det_reg;
    mi3_pkg::adj_t a1_reg [9];
    mi3_pkg::adj_t a2_reg [9];
    mi3_pkg::adj_t a3_reg [9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // column 0 of the matrix times first row of the adjugate
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k]  <= col[k] * $signed({1'b0, adj[k][mi3_pkg::LO_W-1:0]});
                phi_reg[k]  <= col[k] * $signed(adj[k][mi3_pkg::ADJ_W-1:mi3_pkg::LO_W]);
                term_reg[k] <= (mi3_pkg::det_t'(phi_reg[k]) <<< mi3_pkg::LO_W)
                             + mi3_pkg::det_t'(plo_reg[k]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            for (int k = 0; k < 9; k++)
            begin
                a1_reg[k] <= adj[k];
                a2_reg[k] <= a1_reg[k];
                a3_reg[k] <= a2_reg[k];
            end
        end
    end

    assign adj_o = a3_reg;
    assign det   = det_reg;

endmodule

// ===== rtl/core/mi3_div.sv =====
// ============================================================================
// mi3_div
// Pipelined restoring divider: cofactor * 2^SH / det, truncated, saturated.
// One range-check stage, one stage per quotient bit, one output stage.
// ============================================================================
module mi3_div (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [mi3_pkg::ADJ_W-1:0]   adj_mag,
    input  logic                        adj_neg,
    input  logic [mi3_pkg::DET_W-1:0]   det_mag,
    input  logic                        det_neg,
    output mi3_pkg::elem_t              q
);

    localparam int QB = mi3_pkg::QBITS;

    logic [mi3_pkg::NUM_W-1:0] num;
    logic [mi3_pkg::TOP_W-1:0] top;
    logic                      ovf;

    logic [mi3_pkg::DET_W-1:0] rem_reg [QB+1];
    logic [mi3_pkg::DET_W-1:0] d_reg   [QB+1];
    logic [QB-1:0]             lo_reg  [QB+1];
    logic [QB-1:0]             q_reg   [QB+1];
    logic [QB:0]               neg_reg;
    logic [QB:0]               ovf_reg;
    mi3_pkg::elem_t            out_reg;
    logic [mi3_pkg::IN_W-1:0]  qext;

    // range check: quotient overflows when num / 2^QB >= det
    assign num = {adj_mag, {mi3_pkg::SH{1'b0}}};
    assign top = num[mi3_pkg::NUM_W-1:QB];
    assign ovf = mi3_pkg::CMP_W'(top) >= mi3_pkg::CMP_W'(det_mag);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= ovf ? '0 : mi3_pkg::DET_W'(top);
            d_reg[0]   <= det_mag;
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= adj_neg ^ det_neg;
            ovf_reg[0] <= ovf;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [mi3_pkg::REM_W-1:0] trial;
        logic [mi3_pkg::REM_W-1:0] diff;
        logic                      take;

        assign trial = {rem_reg[i-1], lo_reg[i-1][QB-1]};
        assign diff  = trial - {1'b0, d_reg[i-1]};
        assign take  = trial >= {1'b0, d_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= take ? diff[mi3_pkg::DET_W-1:0] : trial[mi3_pkg::DET_W-1:0];
                d_reg[i]   <= d_reg[i-1];
                lo_reg[i]  <= {lo_reg[i-1][QB-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][QB-2:0], take};
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    // sign and saturation
    assign qext = {1'b0, q_reg[QB]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ovf_reg[QB])
                out_reg <= neg_reg[QB] ? mi3_pkg::ELEM_MIN : mi3_pkg::ELEM_MAX;
            else
                out_reg <= neg_reg[QB] ? $signed(-qext) : $signed(qext);
        end
    end

    assign q = out_reg;

endmodule

// ===== rtl/core/matrix3x3_inverse.sv =====
// A request passes through 39 register stages from accept to result valid.
// Throughput: one matrix per cycle unless the output stalls; the 31-stage quotient pipeline sets depth.
// A stalled result holds the whole pipeline in place; nothing is dropped.
// Reset (rst_n low, async) clears all stage valid bits; data is not reset.
// ============================================================================
// matrix3x3_inverse
// Adjugate-based 3x3 fixed-point inverse with determinant and singular flag.
// ============================================================================
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mi3_pkg::elem_t in_00,
    input  mi3_pkg::elem_t in_01,
    input  mi3_pkg::elem_t in_02,
    input  mi3_pkg::elem_t in_10,
    input  mi3_pkg::elem_t in_11,
    input  mi3_pkg::elem_t in_12,
    input  mi3_pkg::elem_t in_20,
    input  mi3_pkg::elem_t in_21,
    input  mi3_pkg::elem_t in_22,
    output logic           out_valid,
    input  logic           out_ready,
    output mi3_pkg::elem_t out_00,
    output mi3_pkg::elem_t out_01,
    output mi3_pkg::elem_t out_02,
    output mi3_pkg::elem_t out_10,
    output mi3_pkg::elem_t out_11,
    output mi3_pkg::elem_t out_12,
    output mi3_pkg::elem_t out_20,
    output mi3_pkg::elem_t out_21,
    output mi3_pkg::elem_t out_22,
    output mi3_pkg::elem_t det_value,
    output logic           singular
);

    localparam int LAT = mi3_pkg::LAT;
    localparam int DL  = mi3_pkg::DIV_LAT;

    logic           adv;
    logic [LAT-1:0] vld_reg;
    mi3_pkg::elem_t m    [9];
    mi3_pkg::adj_t  adj  [9];
    mi3_pkg::elem_t col  [3];
    mi3_pkg::adj_t  adj5 [9];
    mi3_pkg::det_t  det;

    logic [mi3_pkg::ADJ_W-1:0] amag_reg [9];
    logic [8:0]                aneg_reg;
    logic [mi3_pkg::DET_W-1:0] dmag_reg;
    logic                      dneg_reg;
    mi3_pkg::elem_t            dv_reg [DL+1];
    logic [DL:0]               sing_reg;
    logic signed [mi3_pkg::DET_W:0]  dround;
    logic signed [mi3_pkg::DV_W-1:0] dtrunc;
    mi3_pkg::elem_t            dsat;
    mi3_pkg::elem_t            qv [9];

    assign m = '{in_00, in_01, in_02, in_10, in_11, in_12, in_20, in_21, in_22};

    // global stall: move when the output slot is free or being taken
    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    mi3_adj u_adj (
        .clk (clk),
        .adv (adv),
        .m   (m),
        .adj (adj),
        .col (col)
    );

    mi3_det u_det (
        .clk   (clk),
        .adv   (adv),
        .col   (col),
        .adj   (adj),
        .adj_o (adj5),
        .det   (det)
    );

    // determinant truncated toward zero, then saturated
    assign dround = $signed({det[mi3_pkg::DET_W-1], det})
                  + (det[mi3_pkg::DET_W-1]
                     ? $signed({{(mi3_pkg::DET_W+1-mi3_pkg::SH){1'b0}}, {mi3_pkg::SH{1'b1}}})
                     : $signed({(mi3_pkg::DET_W+1){1'b0}}));
    assign dtrunc = mi3_pkg::DV_W'(dround >>> mi3_pkg::SH);
    assign dsat   = (dtrunc > mi3_pkg::ELEM_MAX) ? mi3_pkg::ELEM_MAX :
                    (dtrunc < mi3_pkg::ELEM_MIN) ? mi3_pkg::ELEM_MIN :
                    mi3_pkg::elem_t'(dtrunc);

    // magnitudes and signs for the dividers; side data delay line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                aneg_reg[k] <= adj5[k][mi3_pkg::ADJ_W-1];
                amag_reg[k] <= adj5[k][mi3_pkg::ADJ_W-1] ? mi3_pkg::ADJ_W'(-adj5[k])
                                                         : mi3_pkg::ADJ_W'(adj5[k]);
            end
            dneg_reg    <= det[mi3_pkg::DET_W-1];
            dmag_reg    <= det[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det)
                                                 : mi3_pkg::DET_W'(det);
            sing_reg[0] <= (det == '0);
            dv_reg[0]   <= dsat;
            for (int s = 1; s <= DL; s++)
            begin
                sing_reg[s] <= sing_reg[s-1];
                dv_reg[s]   <= dv_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_div
        mi3_div u_div (
            .clk     (clk),
            .adv     (adv),
            .adj_mag (amag_reg[k]),
            .adj_neg (aneg_reg[k]),
            .det_mag (dmag_reg),
            .det_neg (dneg_reg),
            .q       (qv[k])
        );
    end

    // outputs: a singular matrix reports zero elements
    assign out_valid = vld_reg[LAT-1];
    assign singular  = sing_reg[DL];
    assign det_value = dv_reg[DL];
    assign out_00    = singular ? '0 : qv[0];
    assign out_01    = singular ? '0 : qv[1];
    assign out_02    = singular ? '0 : qv[2];
    assign out_10    = singular ? '0 : qv[3];
    assign out_11    = singular ? '0 : qv[4];
    assign out_12    = singular ? '0 : qv[5];
    assign out_20    = singular ? '0 : qv[6];
    assign out_21    = singular ? '0 : qv[7];
    assign out_22    = singular ? '0 : qv[8];

    `MI3_ASSERT_NOW(a_sing_zero, clk, rst_n, out_valid && singular, det_value == '0 && out_11 == '0)
    `MI3_ASSERT_NOW(a_ready_only_full, clk, rst_n, !in_ready, out_valid && !out_ready)
    `MI3_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_reg[0])
    `MI3_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(vld_reg))

endmodule

// ===== test/tb_matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Self-checking bench for the 3x3 fixed-point inverse. A directed table covers
// identity, zero and extreme matrices, tiny and huge determinants, then
// random matrices run through four idle/stall phases. Every result is
// compared in order against typed values or a wide-integer adjugate predictor.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        mi3_pkg::elem_t el [9];
        mi3_pkg::elem_t det;
        logic           sing;
    } inverse_t;

    localparam int N_RANDOM     = 2000;
    localparam int WDOG_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam mi3_pkg::elem_t ONE_Q = 32'sh0001_0000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           out_ready;
    mi3_pkg::elem_t in_m [9];
    logic           in_ready;
    logic           out_valid;
    mi3_pkg::elem_t out_m [9];
    mi3_pkg::elem_t det_value;
    logic           singular;

    inverse_t inverse_q [$];
    int  n_fail;
    int  idle_pct;
    int  stall_pct;
    bit  hold_req;
    int  quiet_cycles;

    matrix3x3_inverse u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_00(in_m[0]), .in_01(in_m[1]), .in_02(in_m[2]),
        .in_10(in_m[3]), .in_11(in_m[4]), .in_12(in_m[5]),
        .in_20(in_m[6]), .in_21(in_m[7]), .in_22(in_m[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_00(out_m[0]), .out_01(out_m[1]), .out_02(out_m[2]),
        .out_10(out_m[3]), .out_11(out_m[4]), .out_12(out_m[5]),
        .out_20(out_m[6]), .out_21(out_m[7]), .out_22(out_m[8]),
        .det_value(det_value), .singular(singular)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // saturate a wide value to a Q16.16 element
    function automatic mi3_pkg::elem_t sat32(input wide_t v);
        if (v > wide_t'(mi3_pkg::ELEM_MAX))
            return mi3_pkg::ELEM_MAX;
        if (v < wide_t'(mi3_pkg::ELEM_MIN))
            return mi3_pkg::ELEM_MIN;
        return v[31:0];
    endfunction

    // adjugate inverse, exact until the final truncation
    function automatic inverse_t invert_matrix(input mi3_pkg::elem_t m [9]);
        inverse_t r;
        wide_t    adj [9];
        wide_t    det;
        for (int k = 0; k < 9; k++)
            adj[k] = wide_t'(m[mi3_pkg::CO_A[k]]) * wide_t'(m[mi3_pkg::CO_B[k]])
                   - wide_t'(m[mi3_pkg::CO_C[k]]) * wide_t'(m[mi3_pkg::CO_D[k]]);
        det = wide_t'(m[0]) * adj[0] + wide_t'(m[3]) * adj[1] + wide_t'(m[6]) * adj[2];
        r.sing = (det == 0);
        if (r.sing)
        begin
            foreach (r.el[k])
                r.el[k] = '0;
            r.det = '0;
        end
        else
        begin
            foreach (r.el[k])
                r.el[k] = sat32((adj[k] <<< mi3_pkg::SH) / det);
            r.det = sat32(det / (wide_t'(1) <<< mi3_pkg::SH));
        end
        return r;
    endfunction

    // offer one request; record its expectation once accepted
    task automatic send_matrix(input mi3_pkg::elem_t m [9], input bit typed,
                               input inverse_t want);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        foreach (m[k])
            in_m[k] <= m[k];
        do
            @(posedge clk);
        while (!in_ready);
        inverse_q.push_back(typed ? want : invert_matrix(m));
    endtask

    function automatic mi3_pkg::elem_t rand_elem(input int kind);
        mi3_pkg::elem_t v;
        case (kind)
            0: v = mi3_pkg::elem_t'($urandom_range(0, 1 << 19)) - (1 << 18);
            1: v = $urandom;
            2: v = $signed($urandom) >>> $urandom_range(0, 31);
            default:
            begin
                case ($urandom_range(0, 6))
                    0: v = mi3_pkg::ELEM_MAX;
                    1: v = mi3_pkg::ELEM_MIN;
                    2: v = '0;
                    3: v = 32'sd1;
                    4: v = ONE_Q;
                    5: v = -ONE_Q;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        inverse_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (inverse_q.size() == 0)
            begin
                $display("%0t: unexpected result det=%h", $realtime, det_value);
                n_fail++;
            end
            else
            begin
                e = inverse_q.pop_front();
                foreach (e.el[k])
                    if (out_m[k] !== e.el[k])
                    begin
                        $display("%0t: out[%0d] expected %h actual %h",
                                 $realtime, k, e.el[k], out_m[k]);
                        n_fail++;
                    end
                if (det_value !== e.det)
                begin
                    $display("%0t: det_value expected %h actual %h",
                             $realtime, e.det, det_value);
                    n_fail++;
                end
                if (singular !== e.sing)
                begin
                    $display("%0t: singular expected %b actual %b",
                             $realtime, e.sing, singular);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("FAIL matrix3x3_inverse");
            $finish;
        end
    end

    initial
    begin
        mi3_pkg::elem_t dir_m [12][9];
        bit             dir_typed [12];
        inverse_t       dir_want [12];
        mi3_pkg::elem_t m [9];
        inverse_t       none;
        int             kind;
        int             ekind;

        n_fail       = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        foreach (in_m[k])
            in_m[k] = '0;
        none = invert_matrix(in_m);

        // directed table: typed rows where the result is obvious
        foreach (dir_m[r])
        begin
            dir_typed[r] = 1'b0;
            foreach (dir_m[r][k])
                dir_m[r][k] = '0;
            dir_want[r] = none;
        end
        // identity
        dir_m[0] = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        dir_typed[0] = 1'b1;
        dir_want[0].el = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
        dir_want[0].det = ONE_Q;
        dir_want[0].sing = 1'b0;
        // zero matrix: singular
        dir_typed[1] = 1'b1;
        // diag 2.0 -> diag 0.5, det 8.0
        dir_m[2] = '{2 * ONE_Q, 0, 0, 0, 2 * ONE_Q, 0, 0, 0, 2 * ONE_Q};
        dir_typed[2] = 1'b1;
        dir_want[2].el = '{32'sh8000, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000};
        dir_want[2].det = 32'sh8_0000;
        dir_want[2].sing = 1'b0;
        // all max / all min: rank one, singular
        dir_m[3] = '{default: mi3_pkg::ELEM_MAX};
        dir_typed[3] = 1'b1;
        dir_m[4] = '{default: mi3_pkg::ELEM_MIN};
        dir_typed[4] = 1'b1;
        // one lsb on the diagonal: tiny determinant, quotient saturates
        dir_m[5] = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        dir_typed[5] = 1'b1;
        dir_want[5].el = '{mi3_pkg::ELEM_MAX, 0, 0, 0, mi3_pkg::ELEM_MAX, 0, 0, 0,
                           mi3_pkg::ELEM_MAX};
        dir_want[5].det = '0;
        dir_want[5].sing = 1'b0;
        // predicted rows: negative saturation, huge determinants, general
        dir_m[6]  = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
        dir_m[7]  = '{mi3_pkg::ELEM_MAX, 0, 0, 0, mi3_pkg::ELEM_MAX, 0, 0, 0,
                      mi3_pkg::ELEM_MAX};
        dir_m[8]  = '{mi3_pkg::ELEM_MIN, 0, 0, 0, mi3_pkg::ELEM_MIN, 0, 0, 0,
                      mi3_pkg::ELEM_MIN};
        dir_m[9]  = '{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, ONE_Q, 4 * ONE_Q,
                      5 * ONE_Q, 6 * ONE_Q, 0};
        dir_m[10] = '{mi3_pkg::ELEM_MIN, mi3_pkg::ELEM_MAX, 0, mi3_pkg::ELEM_MAX,
                      mi3_pkg::ELEM_MIN, 1, 0, 1, mi3_pkg::ELEM_MIN};
        dir_m[11] = '{-ONE_Q, 3, 32'sh7, mi3_pkg::ELEM_MAX, -5, 32'sh1234_5678,
                      -32'sh10, 32'sh0ABC_DEF0, ONE_Q};

        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_m[r])
            send_matrix(dir_m[r], dir_typed[r], dir_want[r]);

        // random phases; long receiver hold at the start of the first
        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            wait (inverse_q.size() == 0);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++)
            begin
                kind = $urandom_range(99);
                ekind = (kind < 45) ? 0 : (kind < 65) ? 1 : (kind < 80) ? 2 : 3;
                foreach (m[k])
                    m[k] = rand_elem(ekind);
                // sometimes each last-row element is zero or a copy of the first row's
                if ($urandom_range(99) < 12)
                begin
                    for (int c = 0; c < 3; c++)
                        m[6 + c] = ($urandom_range(1) == 1) ? m[c] : '0;
                end
                send_matrix(m, 1'b0, none);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (inverse_q.size() == 0);
        repeat (mi3_pkg::LAT + 10)
            @(posedge clk);
        if (n_fail == 0)
            $display("PASS matrix3x3_inverse");
        else
            $display("FAIL matrix3x3_inverse");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mi3_pkg.sv
rtl/core/mi3_adj.sv
rtl/core/mi3_det.sv
rtl/core/mi3_div.sv
rtl/core/matrix3x3_inverse.sv
test/tb_matrix3x3_inverse.sv
